@@ rtl/swmm_pkg.sv @@
// shared types and constants for the sliding window min/max unit
`timescale 1ns / 1ps
`default_nettype none

package swmm_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned WIN_W    = 9;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [WIN_W-1:0]           win_t;

  // broadcast controls for every cell of one deque
  typedef struct packed {
    logic step;     // an item is taken this cycle
    logic clear;    // treat the deque as empty before this item
    logic shift;    // front entry expires, everything moves one cell forward
    logic cfg_clr;  // window register written, drop all entries
  } swmm_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/swmm_cell.sv @@
// one deque cell: holds a candidate value and its age, pops or takes the new item
`timescale 1ns / 1ps
`default_nettype none

module swmm_cell
  import swmm_pkg::*;
#(
  parameter int unsigned AGE_W = 8
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  swmm_ctrl_t       ctrl_i,
  input  sample_t          key_i,
  input  wire              nbr_valid_i,
  input  sample_t          nbr_value_i,
  input  wire  [AGE_W-1:0] nbr_age_i,
  input  wire              prev_keep_i,
  output logic             keep_o,
  output logic             valid_o,
  output sample_t          value_o,
  output logic [AGE_W-1:0] age_o,
  output sample_t          value_d_o
);

  logic             valid_q, valid_d;
  sample_t          value_q, value_d;
  logic [AGE_W-1:0] age_q, age_d;

  logic             src_valid;
  sample_t          src_value;
  logic [AGE_W-1:0] src_age;
  logic             keep;
  logic             push;

  always_comb begin
    src_valid = (ctrl_i.shift ? nbr_valid_i : valid_q) & ~ctrl_i.clear;
    src_value = ctrl_i.shift ? nbr_value_i : value_q;
    src_age   = ctrl_i.shift ? nbr_age_i : age_q;
    // entries larger than the new item are popped by it
    keep      = src_valid & ~(src_value > key_i);
    push      = ~keep & prev_keep_i;
    valid_d   = keep | push;
    value_d   = keep ? src_value : key_i;
    age_d     = keep ? src_age + AGE_W'(1) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.cfg_clr) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.step) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      value_q <= value_d;
      age_q   <= age_d;
    end
  end

  assign keep_o    = keep;
  assign valid_o   = valid_q;
  assign value_o   = value_q;
  assign age_o     = age_q;
  assign value_d_o = value_d;

endmodule

`default_nettype wire

@@ rtl/swmm_deque.sv @@
// monotonic deque of minimum candidates built as a row of cells
`timescale 1ns / 1ps
`default_nettype none

module swmm_deque
  import swmm_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  wire     clk_i,
  input  wire     rst_ni,
  input  wire     step_i,
  input  wire     clear_i,
  input  wire     cfg_clr_i,
  input  win_t    win_i,
  input  sample_t key_i,
  output sample_t front_d_o
);

  localparam int unsigned AGE_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CMP_W = (AGE_W + 1 > WIN_W) ? AGE_W + 1 : WIN_W;

  logic             valid [DEPTH];
  sample_t          value [DEPTH];
  logic [AGE_W-1:0] age   [DEPTH];
  logic             keep  [DEPTH];
  sample_t          value_d [DEPTH];

  swmm_ctrl_t       ctrl;
  logic [CMP_W-1:0] front_age_inc;

  // ages fall from front to back, so only the front can reach the window length
  assign front_age_inc = CMP_W'(age[0]) + CMP_W'(1);
  assign ctrl.step     = step_i;
  assign ctrl.clear    = clear_i;
  assign ctrl.cfg_clr  = cfg_clr_i;
  assign ctrl.shift    = valid[0] & ~clear_i & (front_age_inc >= CMP_W'(win_i));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic             nbr_valid;
    sample_t          nbr_value;
    logic [AGE_W-1:0] nbr_age;
    logic             prev_keep;

    if (i == DEPTH - 1) begin : g_last
      assign nbr_valid = 1'b0;
      assign nbr_value = '0;
      assign nbr_age   = '0;
    end else begin : g_mid
      assign nbr_valid = valid[i+1];
      assign nbr_value = value[i+1];
      assign nbr_age   = age[i+1];
    end

    if (i == 0) begin : g_first
      assign prev_keep = 1'b1;
    end else begin : g_rest
      assign prev_keep = keep[i-1];
    end

    swmm_cell #(
      .AGE_W(AGE_W)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .key_i      (key_i),
      .nbr_valid_i(nbr_valid),
      .nbr_value_i(nbr_value),
      .nbr_age_i  (nbr_age),
      .prev_keep_i(prev_keep),
      .keep_o     (keep[i]),
      .valid_o    (valid[i]),
      .value_o    (value[i]),
      .age_o      (age[i]),
      .value_d_o  (value_d[i])
    );
  end

  assign front_d_o = value_d[0];

endmodule

`default_nettype wire

@@ rtl/sliding_window_min_max_unit.sv @@
// top level: sliding window minimum and maximum over a sample stream
// a result is registered and on the output in the cycle after its item is accepted
// throughput: one item per cycle while the output is not stalled; every cell of both deques updates in parallel
// an item gives a result once win_eff items (window size, 0 read as 1, capped) have arrived since the last clear
// reset empties both deques, zeroes the fill count and sets the window to 1
// a window write or a start_req item empties the deques as well
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_min_max_unit
  import swmm_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 256
) (
  input  wire     clk_i,
  input  wire     rst_ni,
  input  wire     cfg_we_i,
  input  win_t    cfg_wdata_i,
  input  wire     in_valid_i,
  output logic    in_ready_o,
  input  sample_t sample_i,
  input  wire     start_req_i,
  output logic    out_valid_o,
  input  wire     out_ready_i,
  output sample_t window_min_o,
  output sample_t window_max_o
);

  localparam int unsigned WIN_CAP_I = (MAX_WINDOW > (2 ** WIN_W) - 1) ?
                                      (2 ** WIN_W) - 1 : MAX_WINDOW;
  localparam win_t WIN_CAP = WIN_W'(WIN_CAP_I);

  win_t    window_size_q;
  win_t    fill_q, fill_d, fill_base;
  win_t    win_eff;
  logic    accept;
  logic    has_result;
  logic    out_valid_q;
  sample_t min_q, max_q;
  sample_t min_front, max_front_inv;

  always_comb begin
    if (window_size_q == '0) begin
      win_eff = WIN_W'(1);
    end else if (window_size_q > WIN_CAP) begin
      win_eff = WIN_CAP;
    end else begin
      win_eff = window_size_q;
    end
  end

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    fill_base  = start_req_i ? '0 : fill_q;
    fill_d     = (fill_base < win_eff) ? fill_base + WIN_W'(1) : fill_base;
    has_result = (fill_d >= win_eff);
  end

  // max deque runs on inverted samples so it shares the min cell
  swmm_deque #(
    .DEPTH(MAX_WINDOW)
  ) u_min (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (accept),
    .clear_i  (start_req_i),
    .cfg_clr_i(cfg_we_i),
    .win_i    (win_eff),
    .key_i    (sample_i),
    .front_d_o(min_front)
  );

  swmm_deque #(
    .DEPTH(MAX_WINDOW)
  ) u_max (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (accept),
    .clear_i  (start_req_i),
    .cfg_clr_i(cfg_we_i),
    .win_i    (win_eff),
    .key_i    (~sample_i),
    .front_d_o(max_front_inv)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WIN_W'(1);
      fill_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        window_size_q <= cfg_wdata_i;
        fill_q        <= '0;
      end else if (accept) begin
        fill_q <= fill_d;
      end
      if (accept) begin
        out_valid_q <= has_result;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && has_result) begin
      min_q <= min_front;
      max_q <= ~max_front_inv;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign window_min_o = min_q;
  assign window_max_o = max_q;

endmodule

`default_nettype wire
